>>> rtl/udprhp_pkg.sv
// Shared types, codes and widths for the UDP relay header parser.
`default_nettype none

package udprhp_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int CALC_BITS = (LENGTH_BITS > 9) ? LENGTH_BITS : 9;
    localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    localparam logic [7:0] ATYP_IPV4 = 8'h01;
    localparam logic [7:0] ATYP_IPV6 = 8'h04;
    localparam logic [7:0] ATYP_DOMAIN = 8'h03;

    localparam logic [2:0] ROLE_HEADER = 3'd0;
    localparam logic [2:0] ROLE_ADDRESS = 3'd1;
    localparam logic [2:0] ROLE_DOMAIN_CHAR = 3'd2;
    localparam logic [2:0] ROLE_DOMAIN_DROP = 3'd3;
    localparam logic [2:0] ROLE_PORT = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
    localparam logic [2:0] ROLE_AFTER_BAD = 3'd6;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4 = 2'd1,
        KIND_V6 = 2'd2,
        KIND_DOMAIN = 2'd3
    } t_kind;

    typedef struct packed {
        logic [2:0] role;
        logic [7:0] value;
        logic last;
        logic [LENGTH_BITS-1:0] count;
        t_kind kind;
        logic bad;
        logic [7:0] dom_len;
        logic [15:0] port;
    } t_front_rec;

    function automatic logic [CALC_BITS-1:0] header_end(input t_kind kind,
                                                        input logic [7:0] dom_len);
        logic [CALC_BITS-1:0] hend;
        hend = CALC_BITS'(7) + CALC_BITS'(dom_len);
        if (kind == KIND_V4) begin
            hend = CALC_BITS'(10);
        end else if (kind == KIND_V6) begin
            hend = CALC_BITS'(22);
        end
        return hend;
    endfunction

endpackage

`default_nettype wire

>>> rtl/udp_relay_header_parser_unit.sv
// Top level of the UDP relay header parser: front end, request queue, back end.
`default_nettype none

// The parser takes one datagram byte per clock cycle and returns one result per byte,
// tagged with its role in the relay header; the result for the last byte also carries
// the status, address family, source port and payload length. A byte is accepted every
// cycle while full is low; its result passes through the request queue and then the
// result register before it appears on the result ports.
// The front end's update of the per-datagram state for every accepted byte sets that
// rate, and a four-entry request queue plus the result register absorb result-side stalls.
module udp_relay_header_parser_unit
    import udprhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_byte_role,
    output logic [7:0]       o_byte_value,
    output logic             o_end_of_datagram,
    output logic [1:0]       o_parse_status,
    output logic [1:0]       o_address_family,
    output logic [15:0]      o_source_port,
    output logic [15:0]      o_payload_length,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data
);

    logic accept;
    t_front_rec front_rec;
    t_front_rec queue_rec;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    assign accept = push && !queue_full;
    assign full = queue_full;

    udprhp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_rec         (front_rec)
    );

    udprhp_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr_data (front_rec),
        .i_rd_en   (queue_pop),
        .o_rd_data (queue_rec),
        .o_full    (queue_full),
        .o_empty   (queue_empty)
    );

    udprhp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rec             (queue_rec),
        .i_rec_empty       (queue_empty),
        .o_rec_pop         (queue_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_byte_role       (o_byte_role),
        .o_byte_value      (o_byte_value),
        .o_end_of_datagram (o_end_of_datagram),
        .o_parse_status    (o_parse_status),
        .o_address_family  (o_address_family),
        .o_source_port     (o_source_port),
        .o_payload_length  (o_payload_length)
    );

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("Result queue is not empty after reset.");

    a_summary_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_end_of_datagram) |->
        (o_parse_status == STATUS_OK && o_address_family == 2'd0 &&
         o_source_port == 16'd0 && o_payload_length == 16'd0))
        else $error("Summary fields are set on a request that does not end a datagram.");

    a_failed_summary_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_parse_status != STATUS_OK) |->
        (o_address_family == 2'd0 && o_source_port == 16'd0 &&
         o_payload_length == 16'd0))
        else $error("A failed datagram reports family, port or length.");

    a_bad_type_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_end_of_datagram && o_byte_role == ROLE_AFTER_BAD) |->
        (o_parse_status == STATUS_BAD_TYPE))
        else $error("A datagram with an unknown address type ends without that status.");

endmodule

`default_nettype wire

>>> rtl/udprhp_front.sv
// Front end: per-datagram parse state, byte role tagging and port assembly.
`default_nettype none

module udprhp_front
    import udprhp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    output t_front_rec      o_rec
);

    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    t_kind r_kind, n_kind;
    logic r_bad, n_bad;
    logic [7:0] r_dom_len, n_dom_len;
    logic [15:0] r_port, n_port;
    logic [7:0] r_max_domain_chars;

    logic [2:0] role;
    t_kind kind_eff;
    logic bad_eff;
    logic [7:0] dom_len_eff;
    logic [15:0] port_eff;
    logic [LENGTH_BITS-1:0] count;
    logic [CALC_BITS-1:0] pos_c;
    logic [CALC_BITS-1:0] addr_end;
    logic [CALC_BITS-1:0] hend;

    always_comb begin
        role = ROLE_HEADER;
        kind_eff = r_kind;
        bad_eff = r_bad;
        dom_len_eff = r_dom_len;
        port_eff = r_port;
        pos_c = CALC_BITS'(r_pos);
        hend = header_end(r_kind, r_dom_len);
        addr_end = (r_kind == KIND_DOMAIN) ? (CALC_BITS'(5) + CALC_BITS'(r_dom_len))
                                           : (hend - CALC_BITS'(2));
        if (r_pos < LENGTH_BITS'(3)) begin
            role = ROLE_HEADER;
        end else if (r_pos == LENGTH_BITS'(3)) begin
            role = ROLE_HEADER;
            case (i_data_byte)
                ATYP_IPV4: kind_eff = KIND_V4;
                ATYP_IPV6: kind_eff = KIND_V6;
                ATYP_DOMAIN: kind_eff = KIND_DOMAIN;
                default: bad_eff = 1'b1;
            endcase
        end else if (r_bad || (r_kind == KIND_NONE)) begin
            role = ROLE_AFTER_BAD;
        end else if ((r_kind == KIND_DOMAIN) && (r_pos == LENGTH_BITS'(4))) begin
            role = ROLE_HEADER;
            dom_len_eff = i_data_byte;
        end else if (pos_c < addr_end) begin
            if (r_kind == KIND_DOMAIN) begin
                role = ((pos_c - CALC_BITS'(5)) < CALC_BITS'(r_max_domain_chars))
                       ? ROLE_DOMAIN_CHAR : ROLE_DOMAIN_DROP;
            end else begin
                role = ROLE_ADDRESS;
            end
        end else if (pos_c < hend) begin
            role = ROLE_PORT;
            port_eff = {r_port[7:0], i_data_byte};
        end else begin
            role = ROLE_PAYLOAD;
        end

        count = (r_pos == POS_MAX) ? r_pos : (r_pos + LENGTH_BITS'(1));

        o_rec.role = role;
        o_rec.value = i_data_byte;
        o_rec.last = i_last_byte;
        o_rec.count = count;
        o_rec.kind = kind_eff;
        o_rec.bad = bad_eff;
        o_rec.dom_len = dom_len_eff;
        o_rec.port = port_eff;
    end

    always_comb begin
        n_pos = r_pos;
        n_kind = r_kind;
        n_bad = r_bad;
        n_dom_len = r_dom_len;
        n_port = r_port;
        if (i_accept) begin
            if (i_last_byte) begin
                n_pos = '0;
                n_kind = KIND_NONE;
                n_bad = 1'b0;
                n_dom_len = '0;
                n_port = '0;
            end else begin
                n_pos = count;
                n_kind = kind_eff;
                n_bad = bad_eff;
                n_dom_len = dom_len_eff;
                n_port = port_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_kind <= KIND_NONE;
            r_bad <= 1'b0;
            r_dom_len <= '0;
            r_port <= '0;
            r_max_domain_chars <= 8'hFF;
        end else begin
            r_pos <= n_pos;
            r_kind <= n_kind;
            r_bad <= n_bad;
            r_dom_len <= n_dom_len;
            r_port <= n_port;
            if (i_cfg_wr_en) begin
                r_max_domain_chars <= i_cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/udprhp_fifo.sv
// Short queue of tagged requests between the front end and the back end.
`default_nettype none

module udprhp_fifo
    import udprhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr_en,
    input  wire t_front_rec  i_wr_data,
    input  wire logic        i_rd_en,
    output t_front_rec       o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    t_front_rec r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_PTR_BITS:0] r_level, n_level;
    logic do_wr;
    logic do_rd;

    assign o_full = (r_level == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign o_empty = (r_level == '0);
    assign do_wr = i_wr_en && !o_full;
    assign do_rd = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_wr ? (r_wr_ptr + FIFO_PTR_BITS'(1)) : r_wr_ptr;
        n_rd_ptr = do_rd ? (r_rd_ptr + FIFO_PTR_BITS'(1)) : r_rd_ptr;
        n_level = r_level;
        if (do_wr && !do_rd) begin
            n_level = r_level + (FIFO_PTR_BITS+1)'(1);
        end else if (do_rd && !do_wr) begin
            n_level = r_level - (FIFO_PTR_BITS+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

>>> rtl/udprhp_back.sv
// Back end: datagram status and payload length, and the result register.
`default_nettype none

module udprhp_back
    import udprhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_front_rec  i_rec,
    input  wire logic        i_rec_empty,
    output logic             o_rec_pop,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [2:0]       o_byte_role,
    output logic [7:0]       o_byte_value,
    output logic             o_end_of_datagram,
    output logic [1:0]       o_parse_status,
    output logic [1:0]       o_address_family,
    output logic [15:0]      o_source_port,
    output logic [15:0]      o_payload_length
);

    logic r_valid, n_valid;
    logic [2:0] r_role;
    logic [7:0] r_value;
    logic r_last;
    logic [1:0] r_status;
    logic [1:0] r_family;
    logic [15:0] r_port;
    logic [15:0] r_plen;

    logic [1:0] status;
    logic [1:0] family;
    logic [15:0] port;
    logic [15:0] plen;
    logic [CALC_BITS-1:0] count_c;
    logic [CALC_BITS-1:0] hend;
    logic [CALC_BITS-1:0] diff;
    logic load;

    assign load = !i_rec_empty && (!r_valid || i_pop);
    assign o_rec_pop = load;

    always_comb begin
        status = STATUS_OK;
        family = 2'd0;
        port = '0;
        plen = '0;
        count_c = CALC_BITS'(i_rec.count);
        hend = header_end(i_rec.kind, i_rec.dom_len);
        diff = count_c - hend;
        if (i_rec.last) begin
            if (count_c < CALC_BITS'(4)) begin
                status = STATUS_SHORT;
            end else if (i_rec.bad || (i_rec.kind == KIND_NONE)) begin
                status = STATUS_BAD_TYPE;
            end else if (count_c < hend) begin
                status = STATUS_SHORT;
            end else begin
                status = STATUS_OK;
                family = i_rec.kind - 2'd1;
                port = i_rec.port;
                plen = (diff > CALC_BITS'(17'h0FFFF)) ? 16'hFFFF : 16'(diff);
            end
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_role <= i_rec.role;
            r_value <= i_rec.value;
            r_last <= i_rec.last;
            r_status <= status;
            r_family <= family;
            r_port <= port;
            r_plen <= plen;
        end
    end

    assign o_empty = !r_valid;
    assign o_byte_role = r_role;
    assign o_byte_value = r_value;
    assign o_end_of_datagram = r_last;
    assign o_parse_status = r_status;
    assign o_address_family = r_family;
    assign o_source_port = r_port;
    assign o_payload_length = r_plen;

endmodule

`default_nettype wire
